### rtl/pse_pkg.sv
// Shared types, constants and codes for the postfix stack evaluator.
`timescale 1ns / 1ps
package pse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int MUL_STEPS   = 32;
    localparam int DIV_STEPS   = 48;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    // token kinds
    localparam logic [1:0] MODE_NUM = 2'd0;
    localparam logic [1:0] MODE_OP  = 2'd1;
    localparam logic [1:0] MODE_END = 2'd2;

    // operators
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_UNDER   = 2'd2;
    localparam logic [1:0] ST_OVER    = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] number_value;
        logic [1:0]         operator_code;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [31:0]      wr_data;
    } t_stk_ctl;

    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [31:0] left;
        logic [31:0] right;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_alu_rsp;

endpackage

### rtl/postfix_stack_evaluator.sv
// Top level: token sequencer around the operand stack and the arithmetic unit.
//
//  channel | direction | payload | handshake
//  --------+-----------+---------+------------------------------
//  in      | input     | t_in    | i_in_valid / o_in_stall
//  out     | output    | t_out   | o_out_valid / i_out_stall
//
// A number token is pushed from idle. An operator reads the right, then the left operand,
// then runs pse_alu; multiply and divide take the bit-serial steps of its shared adder.
// An end token reads the top of stack if it is not empty or in error, then waits for the output register to drain.
// Reset empties the stack, clears the status and drops o_out_valid.
// The output register holds a result under stall while the next tokens are taken.
`timescale 1ns / 1ps
module postfix_stack_evaluator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pse_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pse_pkg::t_out o_out
);
    import pse_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_RD_L     = 6'b000010,
        S_ALU_GO   = 6'b000100,
        S_ALU_WAIT = 6'b001000,
        S_END_RD   = 6'b010000,
        S_EMIT     = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [SP_W-1:0] r_sp, n_sp;
    logic [1:0]      r_err, n_err;
    logic [1:0]      r_op, n_op;
    logic [31:0]     r_right, n_right;
    logic [31:0]     r_res, n_res;
    logic [1:0]      r_res_st, n_res_st;
    logic            r_out_valid, n_out_valid;
    t_out            r_out, n_out;

    t_stk_ctl        stk_ctl;
    t_alu_req        alu_req;
    t_alu_rsp        alu_rsp;
    logic [31:0]     rd_data;
    logic [SP_W-1:0] sp_m1, sp_m2;

    assign sp_m1 = r_sp - SP_W'(1);
    assign sp_m2 = r_sp - SP_W'(2);

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_err       = r_err;
        n_op        = r_op;
        n_right     = r_right;
        n_res       = r_res;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid & i_out_stall;
        n_out       = r_out;
        stk_ctl     = '0;
        alu_req     = '0;
        alu_req.op    = r_op;
        alu_req.left  = rd_data;
        alu_req.right = r_right;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in.mode)
                        MODE_NUM: begin
                            if (r_err == ST_OK) begin
                                if (r_sp >= SP_W'(STACK_DEPTH)) begin
                                    n_err = ST_OVER;
                                end else begin
                                    stk_ctl.wr_en   = 1'b1;
                                    stk_ctl.wr_addr = r_sp[IDX_W-1:0];
                                    stk_ctl.wr_data = {i_in.number_value, 16'd0};
                                    n_sp            = r_sp + SP_W'(1);
                                end
                            end
                        end
                        MODE_OP: begin
                            if (r_err == ST_OK) begin
                                if (r_sp < SP_W'(2)) begin
                                    n_err = ST_UNDER;
                                end else begin
                                    stk_ctl.rd_en   = 1'b1;
                                    stk_ctl.rd_addr = sp_m1[IDX_W-1:0];
                                    n_op            = i_in.operator_code;
                                    n_state         = S_RD_L;
                                end
                            end
                        end
                        MODE_END: begin
                            n_sp  = '0;
                            n_err = ST_OK;
                            n_res = '0;
                            if (r_err != ST_OK) begin
                                n_res_st = r_err;
                                n_state  = S_EMIT;
                            end else if (r_sp == '0) begin
                                n_res_st = ST_UNDER;
                                n_state  = S_EMIT;
                            end else begin
                                stk_ctl.rd_en   = 1'b1;
                                stk_ctl.rd_addr = sp_m1[IDX_W-1:0];
                                n_res_st        = ST_OK;
                                n_state         = S_END_RD;
                            end
                        end
                        default: ;  // unused token kind is dropped
                    endcase
                end
            end
            S_RD_L: begin
                // right operand on the read port; fetch the left one
                n_right         = rd_data;
                stk_ctl.rd_en   = 1'b1;
                stk_ctl.rd_addr = sp_m2[IDX_W-1:0];
                n_state         = S_ALU_GO;
            end
            S_ALU_GO: begin
                if ((r_op == OP_DIV) && (r_right == '0)) begin
                    n_err   = ST_DIVZERO;
                    n_state = S_IDLE;
                end else begin
                    alu_req.start = 1'b1;
                    n_state       = S_ALU_WAIT;
                end
            end
            S_ALU_WAIT: begin
                if (alu_rsp.done) begin
                    stk_ctl.wr_en   = 1'b1;
                    stk_ctl.wr_addr = sp_m2[IDX_W-1:0];
                    stk_ctl.wr_data = alu_rsp.result;
                    n_sp            = sp_m1;
                    n_state         = S_IDLE;
                end
            end
            S_END_RD: begin
                n_res   = rd_data;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid        = 1'b1;
                    n_out.result_value = r_res;
                    n_out.status       = r_res_st;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_op     <= n_op;
        r_right  <= n_right;
        r_res    <= n_res;
        r_res_st <= n_res_st;
        r_out    <= n_out;
    end

    pse_stack u_stack (
        .i_clk     (i_clk),
        .i_ctl     (stk_ctl),
        .o_rd_data (rd_data)
    );

    pse_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/pse_stack.sv
// Operand stack storage: one write port, one registered read port.
`timescale 1ns / 1ps
module pse_stack (
    input  logic              i_clk,
    input  pse_pkg::t_stk_ctl i_ctl,
    output logic [31:0]       o_rd_data
);
    import pse_pkg::*;

    logic [31:0] r_mem [STACK_DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/pse_alu.sv
// Q16.16 arithmetic unit: registered add/sub, shared shift-add multiply and restoring divide.
`timescale 1ns / 1ps
module pse_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pse_pkg::t_alu_req i_req,
    output pse_pkg::t_alu_rsp o_rsp
);
    import pse_pkg::*;

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_RUN  = 3'b010,
        A_SAT  = 3'b100
    } t_alu_state;

    t_alu_state       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_is_div, n_is_div;
    logic             r_neg, n_neg;
    logic [31:0]      r_opnd, n_opnd;
    logic [31:0]      r_hi, n_hi;
    logic [47:0]      r_lo, n_lo;
    logic             r_done, n_done;
    logic [31:0]      r_result, n_result;

    logic [31:0] mag_l, mag_r;
    logic [32:0] addsub;
    logic [32:0] a_op;
    logic [31:0] b_op;
    logic [33:0] step_sum;
    logic        ge;
    logic [47:0] mag48;

    function automatic logic [31:0] sat_add(input logic [32:0] s);
        logic [31:0] v;
        if (s[32] != s[31]) begin
            v = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            v = s[31:0];
        end
        return v;
    endfunction

    function automatic logic [31:0] sat_signmag(input logic neg, input logic [47:0] m);
        logic [31:0] v;
        if (neg) begin
            v = (m >= 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-m[31:0]);
        end else begin
            v = (m > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        end
        return v;
    endfunction

    assign mag_l = i_req.left[31]  ? 32'(-i_req.left)  : i_req.left;
    assign mag_r = i_req.right[31] ? 32'(-i_req.right) : i_req.right;

    always_comb begin
        if (i_req.op == OP_SUB) begin
            addsub = {i_req.left[31], i_req.left} - {i_req.right[31], i_req.right};
        end else begin
            addsub = {i_req.left[31], i_req.left} + {i_req.right[31], i_req.right};
        end
    end

    // shared adder: multiply adds the multiplicand, divide trial-subtracts the divisor
    assign a_op     = r_is_div ? {r_hi[31:0], r_lo[47]} : {1'b0, r_hi[31:0]};
    assign b_op     = (r_is_div || r_lo[0]) ? r_opnd : 32'd0;
    assign step_sum = r_is_div ? ({1'b0, a_op} - {2'b00, b_op})
                               : ({1'b0, a_op} + {2'b00, b_op});
    assign ge       = ~step_sum[33];
    assign mag48    = r_is_div ? r_lo : {r_hi[31:0], r_lo[31:16]};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_is_div = r_is_div;
        n_neg    = r_neg;
        n_opnd   = r_opnd;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_done   = 1'b0;
        n_result = r_result;
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_neg = i_req.left[31] ^ i_req.right[31];
                    n_hi  = '0;
                    unique case (i_req.op)
                        OP_ADD, OP_SUB: begin
                            n_result = sat_add(addsub);
                            n_done   = 1'b1;
                        end
                        OP_MUL: begin
                            n_is_div = 1'b0;
                            n_lo     = {16'd0, mag_r};
                            n_opnd   = mag_l;
                            n_cnt    = CNT_W'(MUL_STEPS - 1);
                            n_state  = A_RUN;
                        end
                        OP_DIV: begin
                            n_is_div = 1'b1;
                            n_lo     = {mag_l, 16'd0};
                            n_opnd   = mag_r;
                            n_cnt    = CNT_W'(DIV_STEPS - 1);
                            n_state  = A_RUN;
                        end
                    endcase
                end
            end
            A_RUN: begin
                if (r_is_div) begin
                    // partial remainder stays below the divisor, so 32 bits hold it
                    n_hi = ge ? step_sum[31:0] : a_op[31:0];
                    n_lo = {r_lo[46:0], ge};
                end else begin
                    n_hi = step_sum[32:1];
                    n_lo = {16'd0, step_sum[0], r_lo[31:1]};
                end
                if (r_cnt == '0) begin
                    n_state = A_SAT;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            A_SAT: begin
                n_result = sat_signmag(r_neg, mag48);
                n_done   = 1'b1;
                n_state  = A_IDLE;
            end
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt    <= n_cnt;
        r_is_div <= n_is_div;
        r_neg    <= n_neg;
        r_opnd   <= n_opnd;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_result <= n_result;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

### rtl/pse_checker.sv
// Port-level checks for the postfix stack evaluator, bound to the top level.
`timescale 1ns / 1ps
module pse_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_stall,
    input pse_pkg::t_in  i_in,
    input logic          i_out_valid,
    input logic          i_out_stall,
    input pse_pkg::t_out i_out
);
    import pse_pkg::*;

    // a held result keeps its value until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out))
        else $error("output changed while stalled");

    // an error result always carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out.status != ST_OK) |-> i_out.result_value == '0)
        else $error("error result with nonzero value");

    // only an end token can produce a new result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall && (i_in.mode != MODE_END)
        && !(i_out_valid && i_out_stall) |=> !i_out_valid)
        else $error("result without end token");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_stall)
        else $error("not idle after reset");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in        (i_in),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);

### tb/tb_top.sv
// Self-checking testbench for postfix_stack_evaluator: random RPN token streams.
`timescale 1ns / 1ps
module tb_top;
    import pse_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int TOKEN_TARGET = 850;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 100;

    typedef struct {
        t_in tok;
        bit  drain;   // wait for every pending result before this transfer
    } t_token_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_in  in_tok = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_res;

    postfix_stack_evaluator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_tok),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow evaluator state
    logic [31:0] shadow_stack [STACK_DEPTH];
    int          shadow_depth = 0;
    logic [1:0]  shadow_err = ST_OK;
    t_out        expected_results [$];
    int          n_expected = 0;

    t_token_entry token_q [$];
    bit           drain_next = 1'b0;
    int           n_gen = 0;

    int n_tokens = 0;
    int n_checked = 0;
    int n_fail = 0;
    int status_hits [4] = '{0, 0, 0, 0};
    int burst_left = 8;
    int gap_left = 0;
    int cycles = 0;
    t_out want;

    int  hold_left = 0;
    int  phase_left = 0;
    int  stall_pct = 0;
    bit  hold_a_done = 1'b0;
    bit  hold_b_done = 1'b0;

    function automatic logic [31:0] clamp_q(longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] clamp_signmag(bit neg, longint unsigned m);
        if (neg) return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - m[31:0];
        return (m > 64'h7fff_ffff) ? 32'h7fff_ffff : m[31:0];
    endfunction

    // Advance the shadow evaluator by one accepted token; end tokens queue a result.
    function automatic void evaluate_token(t_in tok);
        longint          l, r;
        longint unsigned ml, mr;
        bit              neg;
        logic [31:0]     res;
        t_out            rslt;
        case (tok.mode)
            MODE_NUM: begin
                if (shadow_err == ST_OK) begin
                    if (shadow_depth >= STACK_DEPTH) begin
                        shadow_err = ST_OVER;
                    end else begin
                        shadow_stack[shadow_depth] = {tok.number_value, 16'h0000};
                        shadow_depth++;
                    end
                end
            end
            MODE_OP: begin
                if (shadow_err != ST_OK) return;
                if (shadow_depth < 2) begin
                    shadow_err = ST_UNDER;
                    return;
                end
                r = longint'($signed(shadow_stack[shadow_depth - 1]));
                l = longint'($signed(shadow_stack[shadow_depth - 2]));
                ml = (l < 0) ? -l : l;
                mr = (r < 0) ? -r : r;
                neg = (l < 0) != (r < 0);
                case (tok.operator_code)
                    OP_ADD: res = clamp_q(l + r);
                    OP_SUB: res = clamp_q(l - r);
                    OP_MUL: res = clamp_signmag(neg, (ml * mr) >> 16);
                    OP_DIV: begin
                        if (r == 0) begin
                            shadow_err = ST_DIVZERO;
                            return;
                        end
                        res = clamp_signmag(neg, (ml << 16) / mr);
                    end
                endcase
                shadow_depth--;
                shadow_stack[shadow_depth - 1] = res;
            end
            MODE_END: begin
                rslt.result_value = '0;
                rslt.status = shadow_err;
                if (shadow_err == ST_OK) begin
                    if (shadow_depth == 0) begin
                        rslt.status = ST_UNDER;
                    end else begin
                        rslt.result_value = shadow_stack[shadow_depth - 1];
                    end
                end
                expected_results.push_back(rslt);
                n_expected++;
                shadow_depth = 0;
                shadow_err = ST_OK;
            end
            default: ;
        endcase
    endfunction

    // stimulus builders
    function automatic void queue_token(logic [1:0] mode, logic [15:0] value,
                                        logic [1:0] op);
        t_token_entry e;
        e.tok.mode = mode;
        e.tok.number_value = value;
        e.tok.operator_code = op;
        e.drain = drain_next;
        drain_next = 1'b0;
        token_q.push_back(e);
        if (mode != MODE_UNUSED) n_gen++;
    endfunction

    function automatic void push_num(logic [15:0] value);
        queue_token(MODE_NUM, value, 2'($urandom_range(0, 3)));
    endfunction

    function automatic void push_op(logic [1:0] op);
        queue_token(MODE_OP, 16'($urandom_range(0, 65535)), op);
    endfunction

    function automatic void push_end();
        queue_token(MODE_END, 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)));
    endfunction

    function automatic logic [15:0] rand_literal();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3, 4, 5, 6: return 16'(int'($urandom_range(0, 40)) - 20);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void gen_expression();
        int d, ops_left, push_pct;
        d = 0;
        ops_left = ($urandom_range(1, 8) == 1) ? $urandom_range(10, 24) : $urandom_range(1, 6);
        push_pct = $urandom_range(35, 85);
        while (ops_left > 0) begin
            if (d < 2 || (d < STACK_DEPTH && $urandom_range(1, 100) <= push_pct)) begin
                push_num(rand_literal());
                d++;
            end else begin
                push_op(2'($urandom_range(0, 3)));
                d--;
                ops_left--;
            end
        end
        while (d > 1) begin
            push_op(2'($urandom_range(0, 3)));
            d--;
        end
        push_end();
    endfunction

    function automatic void gen_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: queue_token(MODE_UNUSED, 16'($urandom_range(0, 65535)),
                               2'($urandom_range(0, 3)));
                1, 2, 3, 4: push_num(rand_literal());
                5, 6, 7: push_op(2'($urandom_range(0, 3)));
                default: push_end();
            endcase
        end
        if ($urandom_range(0, 1)) push_end();
    endfunction

    function automatic void gen_overflow();
        repeat (STACK_DEPTH + 1 + $urandom_range(0, 3)) push_num(rand_literal());
        repeat ($urandom_range(0, 2)) push_op(2'($urandom_range(0, 3)));
        push_end();
    endfunction

    function automatic void gen_underflow();
        repeat ($urandom_range(0, 1)) push_num(rand_literal());
        push_op(2'($urandom_range(0, 3)));
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1)) begin
                push_num(rand_literal());
            end else begin
                push_op(2'($urandom_range(0, 3)));
            end
        end
        push_end();
    endfunction

    // sender: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                evaluate_token(in_tok);
                n_tokens++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (token_q.size() == 0 ||
                             (token_q[0].drain && n_expected != n_checked)) begin
                    in_valid <= 1'b0;
                end else begin
                    in_tok <= token_q[0].tok;
                    in_valid <= 1'b1;
                    void'(token_q.pop_front());
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(1, 10) == 1) ? $urandom_range(40, 80)
                                                                   : $urandom_range(1, 16);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            3: gap_left = $urandom_range(20, 60);
                            default: gap_left = $urandom_range(1, 8);
                        endcase
                    end
                end
            end
        end
    end

    // receiver stall: random phases plus two long hold-offs mid-run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (!hold_a_done && n_checked >= 10) begin
            hold_a_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (!hold_b_done && n_checked >= 60) begin
            hold_b_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            if (phase_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 40;
                    default: stall_pct = 80;
                endcase
                phase_left = $urandom_range(50, 400);
            end else begin
                phase_left--;
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: result_value %0d status %0d",
                       out_res.result_value, out_res.status);
                n_fail++;
            end else begin
                want = expected_results.pop_front();
                if (out_res.result_value !== want.result_value) begin
                    $error("result_value: expected %0d, got %0d",
                           want.result_value, out_res.result_value);
                    n_fail++;
                end
                if (out_res.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_res.status);
                    n_fail++;
                end
                status_hits[want.status]++;
                n_checked <= n_checked + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int pick;
        // directed: empty end, every operator, sub and multiply saturating to the negative limit, error cases
        push_end();
        push_num(16'sd5);
        push_num(16'sd3);
        push_op(OP_ADD);
        push_num(-16'sd2);
        push_op(OP_DIV);
        push_end();
        push_num(16'sh8000);
        push_num(16'sh7fff);
        push_op(OP_SUB);
        push_end();
        push_num(16'sh7fff);
        push_num(16'sh8000);
        push_op(OP_MUL);
        push_end();
        push_num(16'sd1);
        push_num(16'sd0);
        push_op(OP_DIV);
        push_num(16'sd9);
        push_end();
        push_num(16'sd4);
        push_op(OP_ADD);
        push_end();
        push_num(16'sd1);
        queue_token(MODE_UNUSED, 16'hffff, 2'($urandom_range(0, 3)));
        push_num(16'sd2);
        push_end();

        // full stack first, with the sender held until the directed results drain
        drain_next = 1'b1;
        gen_overflow();
        while (n_gen < TOKEN_TARGET) begin
            if ($urandom_range(1, 40) == 1) drain_next = 1'b1;
            pick = $urandom_range(1, 100);
            if (pick <= 70) begin
                gen_expression();
            end else if (pick <= 80) begin
                gen_noise();
            end else if (pick <= 88) begin
                gen_underflow();
            end else if (pick <= 93) begin
                gen_overflow();
            end else begin
                repeat ($urandom_range(2, 5)) push_num(rand_literal());
                push_end();
            end
        end
        push_end();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (token_q.size() != 0 || in_valid || n_expected != n_checked) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d tokens, %0d results: %0d ok, %0d div-by-zero, %0d underflow, %0d overflow",
                 n_tokens, n_checked, status_hits[ST_OK], status_hits[ST_DIVZERO],
                 status_hits[ST_UNDER], status_hits[ST_OVER]);
        if (n_fail == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/pse_pkg.sv
rtl/pse_stack.sv
rtl/pse_alu.sv
rtl/postfix_stack_evaluator.sv
rtl/pse_checker.sv
tb/tb_top.sv
